FILE: rtl/servo_linear_ramp_macros.svh
// Assertion macros for the servo ramp block.
// Used by servo_linear_ramp.sv; expects clk_i and rst_ni in scope.
`ifndef SERVO_LINEAR_RAMP_MACROS_SVH
`define SERVO_LINEAR_RAMP_MACROS_SVH

// Same-cycle implication.
`define SLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/slr_pkg.sv
// Shared types and constants for the servo linear ramp block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

  localparam int unsigned POS_W     = 12;
  localparam int unsigned CHG_W     = 13;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned DUR_IN_W  = 16;
  localparam int unsigned QUO_STEPS = 12;
  localparam int unsigned STEP_W    = 4;

  localparam logic [POS_W-1:0] GOAL_RESET = 12'd500;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_SET  = 2'd2
  } action_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EVAL = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  typedef struct packed {
    action_e             action;
    logic [IDX_W-1:0]    servo_index;
    logic [POS_W-1:0]    new_target;
    logic [DUR_IN_W-1:0] duration_ticks;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] channel;
    logic [POS_W-1:0] position;
    logic             last;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: rtl/servo_linear_ramp.sv
// Servo linear ramp: per-channel timed setpoint ramps, one position beat per channel per tick.
// Depends on slr_pkg and servo_linear_ramp_macros.svh.
//
// Move and set-goal beats are handled in the idle state, which stays ready for the next
// beat. A tick beat walks the channels in order; a settled or expired channel passes
// through eval and emit, a ramping channel through eval, multiply, 12 restoring-divide
// steps on the shared divider, finish and emit; emit waits while the output is stalled.
// Input is not ready while a tick is in progress; the last position beat may still wait
// at the output when the next input beat is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_linear_ramp_macros.svh"

module servo_linear_ramp #(
  parameter int unsigned SERVO_COUNT   = 7,
  parameter int unsigned DURATION_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire slr_pkg::in_beat_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output slr_pkg::out_beat_t     out_data_o
);

  localparam int unsigned CH_W   = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int unsigned DB     = DURATION_BITS;
  localparam int unsigned QS     = slr_pkg::QUO_STEPS;
  localparam int unsigned PROD_W = DB + QS;
  localparam int unsigned POS_W  = slr_pkg::POS_W;
  localparam int unsigned CHG_W  = slr_pkg::CHG_W;
  localparam int unsigned TICK_W = slr_pkg::TICK_W;
  localparam int unsigned STEP_W = slr_pkg::STEP_W;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(SERVO_COUNT - 1);

  // per-channel state
  logic [POS_W-1:0]  cur_q   [SERVO_COUNT];
  logic [POS_W-1:0]  org_q   [SERVO_COUNT];
  logic [POS_W-1:0]  goal_q  [SERVO_COUNT];
  logic [CHG_W-1:0]  chg_q   [SERVO_COUNT];
  logic [TICK_W-1:0] start_q [SERVO_COUNT];
  logic [DB-1:0]     len_q   [SERVO_COUNT];

  slr_pkg::state_e    state_q, state_d;
  logic [TICK_W-1:0]  tick_q, tick_d;
  logic [CH_W-1:0]    ch_q, ch_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [DB-1:0]      el_q, el_d;
  logic [PROD_W-1:0]  acc_q, acc_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               out_valid_q, out_valid_d;
  slr_pkg::out_beat_t out_q, out_d;

  logic              in_fire;
  logic              idx_ok;
  logic [CH_W-1:0]   rd_idx;
  logic [POS_W-1:0]  cur_rd, org_rd, goal_rd;
  logic [CHG_W-1:0]  chg_rd, chg_new;
  logic [TICK_W-1:0] start_rd, elapsed;
  logic [DB-1:0]     len_rd, dur;
  logic              mv_we, set_we, cur_we;
  logic [POS_W-1:0]  mag;
  logic [DB:0]       part, trial;
  logic              ge;
  logic [DB-1:0]     rem;
  logic              neg, round_up;
  logic [POS_W:0]    qa;
  logic [POS_W+1:0]  qs, sum;

  assign in_ready_o  = (state_q == slr_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign idx_ok = (32'(in_data_i.servo_index) < SERVO_COUNT);
  assign rd_idx = in_ready_o ? CH_W'(in_data_i.servo_index) : ch_q;

  assign cur_rd   = cur_q[rd_idx];
  assign org_rd   = org_q[rd_idx];
  assign goal_rd  = goal_q[rd_idx];
  assign chg_rd   = chg_q[rd_idx];
  assign start_rd = start_q[rd_idx];
  assign len_rd   = len_q[rd_idx];

  assign dur     = DB'(in_data_i.duration_ticks);
  assign chg_new = {1'b0, in_data_i.new_target} - {1'b0, cur_rd};
  assign elapsed = tick_q - start_rd;

  // divider step
  assign mag   = chg_rd[CHG_W-1] ? POS_W'(-chg_rd) : chg_rd[POS_W-1:0];
  assign part  = {acc_q[PROD_W-1:QS], acc_q[QS-1]};
  assign trial = part - {1'b0, len_rd};
  assign ge    = !trial[DB];

  // floor adjust
  assign rem      = acc_q[PROD_W-1:QS];
  assign neg      = chg_rd[CHG_W-1];
  assign round_up = neg && (rem != '0);
  assign qa       = {1'b0, acc_q[QS-1:0]} + (POS_W+1)'(round_up);
  assign qs       = neg ? -{1'b0, qa} : {1'b0, qa};
  assign sum      = {2'b00, org_rd} + qs;

  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    ch_d        = ch_q;
    step_d      = step_q;
    el_d        = el_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mv_we       = 1'b0;
    set_we      = 1'b0;
    cur_we      = 1'b0;
    unique case (state_q)
      slr_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.action)
            slr_pkg::ACT_TICK: begin
              tick_d  = tick_q + 1'b1;
              ch_d    = '0;
              state_d = slr_pkg::ST_EVAL;
            end
            slr_pkg::ACT_MOVE: mv_we  = idx_ok;
            slr_pkg::ACT_SET:  set_we = idx_ok;
            default: ;
          endcase
        end
      end
      slr_pkg::ST_EVAL: begin
        el_d = elapsed[DB-1:0];
        if (cur_rd == goal_rd) begin
          pos_d   = cur_rd;
          state_d = slr_pkg::ST_EMIT;
        end else if ((len_rd == '0) || (elapsed > TICK_W'(len_rd))) begin
          pos_d   = goal_rd;
          state_d = slr_pkg::ST_EMIT;
        end else begin
          state_d = slr_pkg::ST_MUL;
        end
      end
      slr_pkg::ST_MUL: begin
        acc_d   = PROD_W'(mag) * PROD_W'(el_q);
        step_d  = '0;
        state_d = slr_pkg::ST_DIV;
      end
      slr_pkg::ST_DIV: begin
        acc_d  = {(ge ? trial[DB-1:0] : part[DB-1:0]), acc_q[QS-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(QS - 1)) begin
          state_d = slr_pkg::ST_FIN;
        end
      end
      slr_pkg::ST_FIN: begin
        priority if (sum[POS_W+1]) begin
          pos_d = '0;
        end else if (sum[POS_W]) begin
          pos_d = '1;
        end else begin
          pos_d = sum[POS_W-1:0];
        end
        state_d = slr_pkg::ST_EMIT;
      end
      slr_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cur_we         = 1'b1;
          out_valid_d    = 1'b1;
          out_d.channel  = slr_pkg::IDX_W'(ch_q);
          out_d.position = pos_q;
          out_d.last     = (ch_q == LAST_CH);
          if (ch_q == LAST_CH) begin
            state_d = slr_pkg::ST_IDLE;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = slr_pkg::ST_EVAL;
          end
        end
      end
      default: state_d = slr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slr_pkg::ST_IDLE;
      tick_q      <= '0;
      ch_q        <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      ch_q        <= ch_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    el_q  <= el_d;
    acc_q <= acc_d;
    pos_q <= pos_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        cur_q[i]   <= '0;
        org_q[i]   <= '0;
        goal_q[i]  <= slr_pkg::GOAL_RESET;
        chg_q[i]   <= '0;
        start_q[i] <= '0;
        len_q[i]   <= '0;
      end
    end else begin
      if (mv_we) begin
        start_q[rd_idx] <= tick_q;
        len_q[rd_idx]   <= dur;
        org_q[rd_idx]   <= cur_rd;
        chg_q[rd_idx]   <= chg_new;
      end
      if (mv_we || set_we) begin
        goal_q[rd_idx] <= in_data_i.new_target;
      end
      if (cur_we) begin
        cur_q[ch_q] <= pos_q;
      end
    end
  end

  `SLR_ASSERT_NEXT(a_tick_busy,
    in_fire && (in_data_i.action == slr_pkg::ACT_TICK), !in_ready_o,
    "tick beat did not start a channel walk")
  `SLR_ASSERT_NOW(a_ch_range, !in_ready_o, 32'(ch_q) < SERVO_COUNT,
    "channel counter out of range")
  `SLR_ASSERT_NOW(a_div_steps, state_q == slr_pkg::ST_DIV, step_q < STEP_W'(QS),
    "divider ran past its step count")
  `SLR_ASSERT_NOW(a_div_rem, state_q == slr_pkg::ST_DIV, rem < len_rd,
    "partial remainder not below divisor")

endmodule

`default_nettype wire
